>>> sv/udp_port_demux_table_assert.svh
// Assertion macros for the UDP port demux table.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef UDP_PORT_DEMUX_TABLE_ASSERT_SVH
`define UDP_PORT_DEMUX_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on the given clock, idle while the given active-low reset is low.
`define UDT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on clk_i, idle during rst_ni.
`define UDT_ASSERT(label, prop, msg) \
  `UDT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define UDT_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define UDT_ASSERT(label, prop, msg)

`endif

`endif

>>> sv/udt_pkg.sv
// Shared types and codes for the UDP port demux table.
// No dependencies; used by the interfaces, the order list and the top level.
package udt_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned QUEUE_MAX = 255;

  typedef logic [3:0] slot_out_t;

  typedef enum logic [1:0] {
    CMD_OPEN    = 2'd0,
    CMD_CLOSE   = 2'd1,
    CMD_DELIVER = 2'd2,
    CMD_RECV    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXISTS     = 3'd1,
    ST_FULL       = 3'd2,
    ST_INVALID    = 3'd3,
    ST_WOULDBLOCK = 3'd4,
    ST_NOPORT     = 3'd5,
    ST_BAD        = 3'd6,
    ST_QFULL      = 3'd7
  } status_e;

  // Order list operations, one per cycle.
  typedef enum logic [2:0] {
    LOP_HOLD = 3'd0,  // keep everything
    LOP_ROT  = 3'd1,  // rotate positions 0..len-1 left by one
    LOP_TAIL = 3'd2,  // rotate positions 1..len-1 left, keep the head
    LOP_DROP = 3'd3,  // drop the head, shift 1..len-1 down
    LOP_PUSH = 3'd4   // insert a new entry at the head
  } list_op_e;

  typedef struct packed {
    list_op_e            op;
    logic [ADDR_W-1:0]   key_addr;
    logic [PORT_W-1:0]   key_port;
  } list_ctrl_t;

endpackage

>>> sv/udt_if.sv
// Request and response channels of the UDP port demux table.
// Depends on udt_pkg for field widths.
interface udt_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [udt_pkg::ADDR_W-1:0] local_address;
  logic [udt_pkg::PORT_W-1:0] local_port;
  logic [3:0]                 handle;
  logic                       broadcast;
  logic                       checksum_bad;
  logic                       header_short;

  modport source (
    output valid, cmd, local_address, local_port, handle, broadcast, checksum_bad,
           header_short,
    input  ready
  );
  modport sink (
    input  valid, cmd, local_address, local_port, handle, broadcast, checksum_bad,
           header_short,
    output ready
  );
endinterface

interface udt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [3:0]                  slot;
  logic [udt_pkg::COUNT_W-1:0] queued_count;
  logic                        send_unreachable;
  logic [31:0]                 in_datagrams;
  logic [31:0]                 no_port_total;
  logic [31:0]                 in_error_total;

  modport source (
    output valid, status, slot, queued_count, send_unreachable, in_datagrams,
           no_port_total, in_error_total,
    input  ready
  );
  modport sink (
    input  valid, status, slot, queued_count, send_unreachable, in_datagrams,
           no_port_total, in_error_total,
    output ready
  );
endinterface

>>> sv/udt_list.sv
// Move-to-front order list of open sockets with the shared match comparator at the head.
// Depends on udt_pkg (list_ctrl_t, list_op_e).
module udt_list #(
  parameter int unsigned N    = 16,
  parameter int unsigned IDXW = 4,
  parameter int unsigned CNTW = 5
) (
  input  logic                clk_i,
  input  udt_pkg::list_ctrl_t ctrl_i,
  input  logic [CNTW-1:0]     len_i,
  input  logic [IDXW-1:0]     push_slot_i,
  output logic [IDXW-1:0]     head_slot_o,
  output logic                match_o
);

  localparam int unsigned EW = IDXW + udt_pkg::ADDR_W + udt_pkg::PORT_W;

  // entry = {slot, address, port}
  logic [EW-1:0]   ent_q [N];
  logic [EW-1:0]   push_ent;
  logic [CNTW-1:0] last;

  logic [udt_pkg::ADDR_W-1:0] head_addr;
  logic [udt_pkg::PORT_W-1:0] head_port;

  assign push_ent = {push_slot_i, ctrl_i.key_addr, ctrl_i.key_port};
  assign last     = len_i - CNTW'(1);

  for (genvar k = 0; k < N; k++) begin : g_pos
    localparam logic [CNTW-1:0] K = CNTW'(k);
    logic [EW-1:0] above;
    logic [EW-1:0] below;
    logic [EW-1:0] ent_d;

    if (k == N - 1) begin : g_top
      assign above = ent_q[k];
    end else begin : g_mid
      assign above = ent_q[k+1];
    end

    if (k == 0) begin : g_first
      assign below = push_ent;
    end else begin : g_rest
      assign below = ent_q[k-1];
    end

    always_comb begin
      ent_d = ent_q[k];
      case (ctrl_i.op)
        udt_pkg::LOP_PUSH: ent_d = below;
        udt_pkg::LOP_ROT: begin
          if (K == last) ent_d = ent_q[0];
          else if (K < last) ent_d = above;
        end
        udt_pkg::LOP_TAIL: begin
          if (K != '0) begin
            if (K == last) ent_d = ent_q[1];
            else if (K < last) ent_d = above;
          end
        end
        udt_pkg::LOP_DROP: begin
          if (K < last) ent_d = above;
        end
        default: ent_d = ent_q[k];
      endcase
    end

    always_ff @(posedge clk_i) begin
      ent_q[k] <= ent_d;
    end
  end

  assign {head_slot_o, head_addr, head_port} = ent_q[0];

  // Wildcard entries (address 0) match any key address.
  assign match_o = (head_port == ctrl_i.key_port) &&
                   ((head_addr == ctrl_i.key_addr) || (head_addr == '0));

endmodule

>>> sv/udp_port_demux_table.sv
// UDP port demux table: socket table with move-to-front lookup and per-socket queue counts.
// Depends on udt_pkg, udt_if.sv, udt_list and udp_port_demux_table_assert.svh.
//
//  channel   | dir | handshake             | carries
//  ----------+-----+-----------------------+-----------------------------------------
//  req_i     | in  | valid/ready           | cmd, address, port, handle, deliver flags
//  rsp_o     | out | valid/ready           | status, slot, count, unreachable, counters
//  cfg_*     | in  | cfg_we_i, no wait     | interface address (broadcast key)
//
//  Sequence: open and deliver walk the list one entry per cycle (T = open sockets, at
//  most TABLE_ENTRIES) and read the pending count on a hit; close walks it too; receive
//  only reads the count; a bad datagram, bad handle or empty-table lookup skips the walk.
//  The walk is set by the single comparator at the head of the order list.
//  Reset clears the valid bits, socket count and counters at once; no clearing pass.
//  A finished response waits in the output register; a new request is taken meanwhile,
//  and only the final step stalls until that register is free.
`include "udp_port_demux_table_assert.svh"

module udp_port_demux_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned QUEUE_LIMIT   = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  udt_req_if.sink     req_i,
  udt_rsp_if.source   rsp_o
);

  localparam int unsigned IDXW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned QCAP = (QUEUE_LIMIT < udt_pkg::QUEUE_MAX) ? QUEUE_LIMIT
                                                                     : udt_pkg::QUEUE_MAX;
  localparam logic [udt_pkg::COUNT_W-1:0] QCAP_C = udt_pkg::COUNT_W'(QCAP);
  localparam logic [CNTW-1:0]             FULL_C = CNTW'(TABLE_ENTRIES);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_LOOK = 3'd1;  // lookup walk, one list entry per cycle
  localparam logic [2:0] S_DROP = 3'd2;  // close walk, removes the handle from the list
  localparam logic [2:0] S_RD   = 3'd3;  // pending count read
  localparam logic [2:0] S_FIN  = 3'd4;  // commit and load the response register

  // ---------------------------------------------------------------- state
  logic [2:0]               state_q, state_d;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [CNTW-1:0]          total_q;
  logic [31:0]              acc_q, acc_d;
  logic [31:0]              nop_q, nop_d;
  logic [31:0]              err_q, err_d;
  logic [31:0]              iface_q;

  // Latched request and walk bookkeeping
  udt_pkg::cmd_e              cmd_q;
  logic [udt_pkg::ADDR_W-1:0] key_addr_q;
  logic [udt_pkg::PORT_W-1:0] key_port_q;
  logic [3:0]                 handle_q;
  logic                       bcast_q;
  logic                       bad_q;
  logic                       hdl_ok_q;
  logic                       hit_q;
  logic [IDXW-1:0]            slot_q;
  logic [IDXW-1:0]            step_q;
  logic [CNTW-1:0]            rem_q;
  logic [CNTW-1:0]            len_q;
  logic [IDXW-1:0]            free_q;
  logic                       free_ok_q;

  // Pending-count memory, registered read at slot_q
  logic [udt_pkg::COUNT_W-1:0] pend_mem [TABLE_ENTRIES];
  logic [udt_pkg::COUNT_W-1:0] pend_rd_q;
  logic                        pend_we;
  logic [IDXW-1:0]             pend_waddr;
  logic [udt_pkg::COUNT_W-1:0] pend_wdata;

  // Response register
  logic                        rsp_valid_q;
  udt_pkg::status_e            rsp_status_q, st_res;
  udt_pkg::slot_out_t          rsp_slot_q, slot_res;
  logic [udt_pkg::COUNT_W-1:0] rsp_queued_q, queue_res;
  logic                        rsp_unr_q, unr_res;

  // ---------------------------------------------------------------- order list
  udt_pkg::list_ctrl_t lctl;
  logic [IDXW-1:0]     head_slot;
  logic                match;
  logic [IDXW-1:0]     free_slot;

  udt_list #(
    .N    (TABLE_ENTRIES),
    .IDXW (IDXW),
    .CNTW (CNTW)
  ) u_list (
    .clk_i       (clk_i),
    .ctrl_i      (lctl),
    .len_i       (len_q),
    .push_slot_i (free_slot),
    .head_slot_o (head_slot),
    .match_o     (match)
  );

  // ---------------------------------------------------------------- request decode
  logic          accept;
  logic          done;
  logic          out_free;
  logic          req_hdl_ok;
  logic          req_bad;
  udt_pkg::cmd_e req_cmd;
  logic          valid_set, valid_clr;
  logic          total_inc, total_dec;
  logic          last_step;
  logic          drop_now;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_cmd     = udt_pkg::cmd_e'(req_i.cmd);
  assign req_bad     = req_i.checksum_bad || req_i.header_short;
  // Out-of-range handles never look at the valid bits.
  assign req_hdl_ok  = (int'(req_i.handle) < TABLE_ENTRIES) &&
                       valid_q[IDXW'(req_i.handle)];

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign last_step = (rem_q == CNTW'(1));
  assign drop_now  = !hit_q && (head_slot == slot_q);

  // Lowest free slot: the walk scans valid bits 0..T-1; with fewer than
  // TABLE_ENTRIES sockets open, slot T is free if none of those was.
  assign free_slot = free_ok_q ? free_q : total_q[IDXW-1:0];

  always_comb begin
    state_d       = state_q;
    lctl.op       = udt_pkg::LOP_HOLD;
    lctl.key_addr = key_addr_q;
    lctl.key_port = key_port_q;
    st_res        = udt_pkg::ST_OK;
    slot_res      = '0;
    queue_res     = '0;
    unr_res       = 1'b0;
    acc_d         = acc_q;
    nop_d         = nop_q;
    err_d         = err_q;
    pend_we       = 1'b0;
    pend_waddr    = slot_q;
    pend_wdata    = '0;
    valid_set     = 1'b0;
    valid_clr     = 1'b0;
    total_inc     = 1'b0;
    total_dec     = 1'b0;
    done          = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_cmd)
            udt_pkg::CMD_OPEN:    state_d = (total_q == '0) ? S_FIN : S_LOOK;
            udt_pkg::CMD_DELIVER: state_d = (req_bad || total_q == '0) ? S_FIN : S_LOOK;
            udt_pkg::CMD_CLOSE:   state_d = req_hdl_ok ? S_DROP : S_FIN;
            udt_pkg::CMD_RECV:    state_d = req_hdl_ok ? S_RD : S_FIN;
            default:              state_d = S_FIN;
          endcase
        end
      end

      S_LOOK: begin
        // Rotate until the head matches; after a hit the head stays put and the
        // remainder rotates back into its original order.
        if (hit_q)      lctl.op = udt_pkg::LOP_TAIL;
        else if (match) lctl.op = udt_pkg::LOP_HOLD;
        else            lctl.op = udt_pkg::LOP_ROT;
        if (last_step) state_d = (hit_q || match) ? S_RD : S_FIN;
      end

      S_DROP: begin
        lctl.op = drop_now ? udt_pkg::LOP_DROP : udt_pkg::LOP_ROT;
        if (last_step) state_d = S_FIN;
      end

      S_RD: state_d = S_FIN;

      S_FIN: begin
        case (cmd_q)
          udt_pkg::CMD_OPEN: begin
            if (hit_q) begin
              st_res    = udt_pkg::ST_EXISTS;
              slot_res  = udt_pkg::slot_out_t'(slot_q);
              queue_res = pend_rd_q;
            end else if (total_q == FULL_C) begin
              st_res = udt_pkg::ST_FULL;
            end else begin
              slot_res   = udt_pkg::slot_out_t'(free_slot);
              valid_set  = 1'b1;
              total_inc  = 1'b1;
              pend_we    = 1'b1;
              pend_waddr = free_slot;
              lctl.op    = udt_pkg::LOP_PUSH;
            end
          end
          udt_pkg::CMD_CLOSE: begin
            slot_res = handle_q;
            if (!hdl_ok_q) begin
              st_res = udt_pkg::ST_INVALID;
            end else begin
              valid_clr = 1'b1;
              total_dec = 1'b1;
            end
          end
          udt_pkg::CMD_DELIVER: begin
            if (bad_q) begin
              st_res = udt_pkg::ST_BAD;
              err_d  = err_q + 32'd1;
            end else if (!hit_q) begin
              st_res  = udt_pkg::ST_NOPORT;
              nop_d   = nop_q + 32'd1;
              unr_res = !bcast_q;
            end else begin
              slot_res = udt_pkg::slot_out_t'(slot_q);
              if (pend_rd_q >= QCAP_C) begin
                st_res    = udt_pkg::ST_QFULL;
                queue_res = pend_rd_q;
              end else begin
                queue_res  = pend_rd_q + 8'd1;
                pend_we    = 1'b1;
                pend_wdata = queue_res;
                acc_d      = acc_q + 32'd1;
              end
            end
          end
          udt_pkg::CMD_RECV: begin
            slot_res = handle_q;
            if (!hdl_ok_q) begin
              st_res = udt_pkg::ST_INVALID;
            end else if (pend_rd_q == '0) begin
              st_res = udt_pkg::ST_WOULDBLOCK;
            end else begin
              queue_res  = pend_rd_q - 8'd1;
              pend_we    = 1'b1;
              pend_wdata = queue_res;
            end
          end
          default: st_res = udt_pkg::ST_OK;
        endcase

        // Commit only once the response register can take the result.
        if (out_free) begin
          done    = 1'b1;
          state_d = S_IDLE;
        end else begin
          lctl.op   = udt_pkg::LOP_HOLD;
          pend_we   = 1'b0;
          valid_set = 1'b0;
          valid_clr = 1'b0;
          total_inc = 1'b0;
          total_dec = 1'b0;
          acc_d     = acc_q;
          nop_d     = nop_q;
          err_d     = err_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      total_q     <= '0;
      acc_q       <= '0;
      nop_q       <= '0;
      err_q       <= '0;
      iface_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      nop_q   <= nop_d;
      err_q   <= err_d;
      if (cfg_we_i) iface_q <= cfg_wdata_i;
      if (valid_set) valid_q[free_slot] <= 1'b1;
      if (valid_clr) valid_q[slot_q]    <= 1'b0;
      if (total_inc)      total_q <= total_q + CNTW'(1);
      else if (total_dec) total_q <= total_q - CNTW'(1);
      if (done)              rsp_valid_q <= 1'b1;
      else if (rsp_o.ready)  rsp_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- request and walk registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= req_cmd;
      key_addr_q <= (req_cmd == udt_pkg::CMD_DELIVER && req_i.broadcast) ? iface_q
                                                                          : req_i.local_address;
      key_port_q <= req_i.local_port;
      handle_q   <= req_i.handle;
      bcast_q    <= req_i.broadcast;
      bad_q      <= req_bad;
      hdl_ok_q   <= req_hdl_ok;
      hit_q      <= 1'b0;
      slot_q     <= IDXW'(req_i.handle);
      step_q     <= '0;
      rem_q      <= total_q;
      len_q      <= total_q;
      free_ok_q  <= 1'b0;
    end else if (state_q == S_LOOK) begin
      step_q <= step_q + IDXW'(1);
      rem_q  <= rem_q - CNTW'(1);
      if (!free_ok_q && !valid_q[step_q]) begin
        free_q    <= step_q;
        free_ok_q <= 1'b1;
      end
      if (!hit_q && match) begin
        hit_q  <= 1'b1;
        slot_q <= head_slot;
      end
    end else if (state_q == S_DROP) begin
      rem_q <= rem_q - CNTW'(1);
      if (drop_now) begin
        hit_q <= 1'b1;
        len_q <= len_q - CNTW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- pending counts
  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    pend_rd_q <= pend_mem[slot_q];
  end

  // ---------------------------------------------------------------- response register
  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_status_q <= st_res;
      rsp_slot_q   <= slot_res;
      rsp_queued_q <= queue_res;
      rsp_unr_q    <= unr_res;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = rsp_status_q;
  assign rsp_o.slot             = rsp_slot_q;
  assign rsp_o.queued_count     = rsp_queued_q;
  assign rsp_o.send_unreachable = rsp_unr_q;
  assign rsp_o.in_datagrams     = acc_q;
  assign rsp_o.no_port_total    = nop_q;
  assign rsp_o.in_error_total   = err_q;

  // ---------------------------------------------------------------- checks
  `UDT_ASSERT(a_total_bound, total_q <= FULL_C, "socket count above table size")
  `UDT_ASSERT(a_total_valid, $countones(valid_q) == int'(total_q), "socket count out of sync")
  `UDT_ASSERT(a_one_at_a_time, accept |=> !req_i.ready, "request taken while busy")
  `UDT_ASSERT(a_fin_waits, (state_q == S_FIN && !out_free) |=> (state_q == S_FIN), "result dropped")

endmodule

>>> verif/udt_response_checker.sv
`timescale 1ns / 100ps
// Response checker for the UDP port demux table: mirrors the socket table and compares responses.
// Depends on udt_pkg and the request/response interfaces in udt_if.sv.
module udt_response_checker #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned QUEUE_LIMIT   = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  udt_req_if          req_i,
  udt_rsp_if          rsp_i,
  output int unsigned mismatch_total_o,
  output int unsigned results_owed_o
);

  // Pending count saturates at the limit or at the 8-bit width, whichever is lower.
  localparam int unsigned DEPTH_CAP = (QUEUE_LIMIT < 255) ? QUEUE_LIMIT : 255;

  typedef struct packed {
    udt_pkg::status_e status;
    logic [3:0]       slot;
    logic [7:0]       queued;
    logic             unreach;
    logic [31:0]      datagrams;
    logic [31:0]      no_port;
    logic [31:0]      errors;
  } sock_result_t;

  logic [31:0]  iface_addr;
  bit           sock_open  [TABLE_ENTRIES];
  logic [31:0]  sock_addr  [TABLE_ENTRIES];
  logic [15:0]  sock_port  [TABLE_ENTRIES];
  logic [7:0]   sock_depth [TABLE_ENTRIES];
  int unsigned  lookup_order[$];   // front is most recently hit
  logic [31:0]  datagram_cnt;
  logic [31:0]  no_port_cnt;
  logic [31:0]  error_cnt;
  sock_result_t owed_results[$];
  sock_result_t want;

  // First match in move-to-front order; address 0 on the socket is a wildcard.
  function automatic int find_listener(logic [31:0] key_addr, logic [15:0] key_port);
    int unsigned s;
    for (int i = 0; i < lookup_order.size(); i++) begin
      s = lookup_order[i];
      if (sock_open[s] && sock_port[s] == key_port &&
          (sock_addr[s] == key_addr || sock_addr[s] == '0)) begin
        lookup_order.delete(i);
        lookup_order.push_front(s);
        return int'(s);
      end
    end
    return -1;
  endfunction

  function automatic sock_result_t predict_request(udt_pkg::cmd_e cmd, logic [31:0] addr,
      logic [15:0] port, logic [3:0] handle, logic bcast, logic ck_bad, logic hdr_short);
    sock_result_t r;
    int           hit;
    int unsigned  free_slot;
    r = '0;
    r.status = udt_pkg::ST_OK;
    case (cmd)
      udt_pkg::CMD_OPEN: begin
        hit = find_listener(addr, port);
        if (hit >= 0) begin
          r.status = udt_pkg::ST_EXISTS;
          r.slot   = 4'(hit);
          r.queued = sock_depth[hit];
        end else if (lookup_order.size() >= TABLE_ENTRIES) begin
          r.status = udt_pkg::ST_FULL;
        end else begin
          free_slot = 0;
          while (free_slot < TABLE_ENTRIES && sock_open[free_slot]) free_slot++;
          if (free_slot >= TABLE_ENTRIES) begin
            r.status = udt_pkg::ST_FULL;
          end else begin
            sock_open[free_slot]  = 1'b1;
            sock_addr[free_slot]  = addr;
            sock_port[free_slot]  = port;
            sock_depth[free_slot] = '0;
            lookup_order.push_front(free_slot);
            r.slot = 4'(free_slot);
          end
        end
      end
      udt_pkg::CMD_CLOSE: begin
        r.slot = handle;
        if (handle >= TABLE_ENTRIES || !sock_open[handle]) begin
          r.status = udt_pkg::ST_INVALID;
        end else begin
          for (int i = 0; i < lookup_order.size(); i++) begin
            if (lookup_order[i] == handle) begin
              lookup_order.delete(i);
              break;
            end
          end
          sock_open[handle]  = 1'b0;
          sock_depth[handle] = '0;
        end
      end
      udt_pkg::CMD_DELIVER: begin
        if (ck_bad || hdr_short) begin
          error_cnt++;
          r.status = udt_pkg::ST_BAD;
        end else begin
          hit = find_listener(bcast ? iface_addr : addr, port);
          if (hit < 0) begin
            no_port_cnt++;
            r.status  = udt_pkg::ST_NOPORT;
            r.unreach = !bcast;
          end else begin
            r.slot = 4'(hit);
            if (sock_depth[hit] >= DEPTH_CAP) begin
              r.status = udt_pkg::ST_QFULL;
            end else begin
              sock_depth[hit]++;
              datagram_cnt++;
            end
            r.queued = sock_depth[hit];
          end
        end
      end
      default: begin
        r.slot = handle;
        if (handle >= TABLE_ENTRIES || !sock_open[handle]) begin
          r.status = udt_pkg::ST_INVALID;
        end else if (sock_depth[handle] == '0) begin
          r.status = udt_pkg::ST_WOULDBLOCK;
        end else begin
          sock_depth[handle]--;
          r.queued = sock_depth[handle];
        end
      end
    endcase
    r.datagrams = datagram_cnt;
    r.no_port   = no_port_cnt;
    r.errors    = error_cnt;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_val,
                                        logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatch_total_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iface_addr   = '0;
      datagram_cnt = '0;
      no_port_cnt  = '0;
      error_cnt    = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        sock_open[i]  = 1'b0;
        sock_depth[i] = '0;
      end
      lookup_order.delete();
      owed_results.delete();
      results_owed_o = 0;
    end else begin
      if (cfg_we_i) iface_addr = cfg_wdata_i;

      // The response register loads only in the final state, which follows the idle state
      // that takes a request, so a response never belongs to a request taken at the same edge.
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual status %0h",
                   $time, rsp_i.status);
          mismatch_total_o++;
        end else begin
          want = owed_results.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp_i.status));
          compare_field("slot", 32'(want.slot), 32'(rsp_i.slot));
          compare_field("queued_count", 32'(want.queued), 32'(rsp_i.queued_count));
          compare_field("send_unreachable", 32'(want.unreach),
                        32'(rsp_i.send_unreachable));
          compare_field("in_datagrams", want.datagrams, rsp_i.in_datagrams);
          compare_field("no_port_total", want.no_port, rsp_i.no_port_total);
          compare_field("in_error_total", want.errors, rsp_i.in_error_total);
        end
      end

      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        owed_results.push_back(predict_request(udt_pkg::cmd_e'(req_i.cmd),
            req_i.local_address, req_i.local_port, req_i.handle, req_i.broadcast,
            req_i.checksum_bad, req_i.header_short));
      end

      results_owed_o = owed_results.size();
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for udp_port_demux_table: clock, reset, request stimulus and verdict.
// Depends on udt_pkg, udt_if.sv, the block itself and udt_response_checker.
module tb_top;

  localparam int unsigned TABLE_ENTRIES   = 16;
  localparam int unsigned QUEUE_LIMIT     = 255;
  // Settle for twice the longest request, a full walk plus count read, before touching config.
  localparam int unsigned DRAIN_CYCLES    = 2 * (3 + TABLE_ENTRIES) + 4;
  // Long response hold-off, long enough to back up the block into the request side.
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int unsigned mismatch_total;
  int unsigned results_owed;

  // Shared knobs between the request driver and the response-ready driver.
  bit steady_mode;    // no idle cycles on either side
  bit hold_off_req;   // ask the ready driver for one long stall

  // Small key pools so that opens collide and deliveries find listeners.
  logic [15:0] port_pool [8];
  logic [31:0] addr_pool [4];

  udt_req_if req_ch ();
  udt_rsp_if rsp_ch ();

  udp_port_demux_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .QUEUE_LIMIT  (QUEUE_LIMIT)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  udt_response_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .QUEUE_LIMIT  (QUEUE_LIMIT)
  ) checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .req_i           (req_ch),
    .rsp_i           (rsp_ch),
    .mismatch_total_o(mismatch_total),
    .results_owed_o  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle run length: mostly a few cycles, now and then a long one.
  function automatic int unsigned stall_length();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // Response side: random runs of ready high and low. No run is empty,
  // so ready gets a single assignment per edge.
  initial begin : rsp_ready_driver
    bit          ready_level;
    int unsigned run;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        ready_level  = 1'b0;
        run          = HOLD_OFF_CYCLES;
      end else if (!steady_mode && $urandom_range(0, 3) == 0) begin
        ready_level = 1'b0;
        run         = stall_length();
      end else begin
        ready_level = 1'b1;
        run         = $urandom_range(1, 30);
      end
      rsp_ch.ready <= ready_level;
      repeat (run) @(posedge clk);
    end
  end

  // Offer one request and return at the edge where it is taken. valid is only
  // dropped when a gap precedes the request, so back-to-back requests keep it high.
  task automatic send_request(udt_pkg::cmd_e cmd, logic [31:0] addr, logic [15:0] port,
                              logic [3:0] handle, logic bcast, logic ck_bad,
                              logic hdr_short);
    int unsigned gap;
    gap = (steady_mode || $urandom_range(0, 99) < 60) ? 0 : stall_length();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= cmd;
    req_ch.local_address <= addr;
    req_ch.local_port    <= port;
    req_ch.handle        <= handle;
    req_ch.broadcast     <= bcast;
    req_ch.checksum_bad  <= ck_bad;
    req_ch.header_short  <= hdr_short;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Stop offering, wait for every owed response, then let the block settle.
  // The first edge lets the checker log the request taken at the current one.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_address();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;            // wildcard on open
    if (pick < 80) return addr_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(0, 99) < 85) return port_pool[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  // Random command mix by weight; handle and the deliver flags are random on
  // every command, so fields that a command ignores still toggle.
  task automatic random_phase(int unsigned count, int unsigned w_open, int unsigned w_close,
                              int unsigned w_deliver, int unsigned w_recv);
    int unsigned   pick;
    udt_pkg::cmd_e cmd;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, w_open + w_close + w_deliver + w_recv - 1);
      if (pick < w_open)                            cmd = udt_pkg::CMD_OPEN;
      else if (pick < w_open + w_close)             cmd = udt_pkg::CMD_CLOSE;
      else if (pick < w_open + w_close + w_deliver) cmd = udt_pkg::CMD_DELIVER;
      else                                          cmd = udt_pkg::CMD_RECV;
      send_request(cmd, pick_address(), pick_port(), 4'($urandom_range(0, 15)),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0);
    end
  endtask

  // Empty the table, open one socket and pour datagrams into it faster than
  // they are received, so its pending count runs into the limit.
  // Expects the interface address to equal the socket address, so broadcasts hit too.
  task automatic flood_phase(int unsigned count);
    int unsigned pick;
    for (int h = 0; h < TABLE_ENTRIES; h++)
      send_request(udt_pkg::CMD_CLOSE, pick_address(), pick_port(), 4'(h),
                   1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_OPEN, addr_pool[1], port_pool[2], 4'd0, 1'b0, 1'b0, 1'b0);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_request(udt_pkg::CMD_DELIVER, addr_pool[1], port_pool[2],
                     4'($urandom_range(0, 15)),
                     $urandom_range(0, 3) == 0, $urandom_range(0, 39) == 0, 1'b0);
      end else if (pick < 92) begin
        send_request(udt_pkg::CMD_RECV, pick_address(), pick_port(),
                     4'($urandom_range(0, 3)), 1'b0, 1'b0, 1'b0);
      end else begin
        random_phase(1, 1, 1, 2, 1);
      end
    end
  endtask

  initial begin : watchdog
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    // Every block input known from time zero.
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.cmd           <= udt_pkg::CMD_OPEN;
    req_ch.local_address <= '0;
    req_ch.local_port    <= '0;
    req_ch.handle        <= '0;
    req_ch.broadcast     <= 1'b0;
    req_ch.checksum_bad  <= 1'b0;
    req_ch.header_short  <= 1'b0;
    steady_mode  = 1'b0;
    hold_off_req = 1'b0;

    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom);
    addr_pool[0] = 32'hFFFF_FFFF;
    for (int i = 1; i < 4; i++) addr_pool[i] = $urandom | 32'h1;  // never the wildcard

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: broadcast key is 192.168.0.1 here.
    write_config(32'hC0A8_0001);
    // Empty table: bad handles, no listener with and without broadcast.
    send_request(udt_pkg::CMD_RECV,    '0, '0, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_CLOSE,   '1, '1, 4'd15, 1'b1, 1'b1, 1'b1);
    send_request(udt_pkg::CMD_DELIVER, 32'h0A00_0001, 16'd7, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_DELIVER, 32'h0A00_0001, 16'd7, 4'd0, 1'b1, 1'b0, 1'b0);
    // Bad checksum, short header, and both at once (all give the same status).
    send_request(udt_pkg::CMD_DELIVER, '1, '1, 4'd0, 1'b0, 1'b1, 1'b0);
    send_request(udt_pkg::CMD_DELIVER, '1, '1, 4'd0, 1'b0, 1'b0, 1'b1);
    send_request(udt_pkg::CMD_DELIVER, '1, '1, 4'd0, 1'b1, 1'b1, 1'b1);
    // Wildcard socket on port 0 and an all-ones socket, then duplicates.
    send_request(udt_pkg::CMD_OPEN,    '0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_OPEN,    '1, 16'hFFFF, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_OPEN,    '1, 16'hFFFF, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_OPEN,    32'd5, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0);
    // Unicast hit, broadcast hit on the wildcard, broadcast miss on the all-ones socket.
    send_request(udt_pkg::CMD_DELIVER, '1, 16'hFFFF, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_DELIVER, '0, 16'h0000, 4'd0, 1'b1, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_DELIVER, '0, 16'hFFFF, 4'd0, 1'b1, 1'b0, 1'b0);
    // Socket on the interface address catches that broadcast.
    send_request(udt_pkg::CMD_OPEN,    32'hC0A8_0001, 16'hFFFF, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_DELIVER, '0, 16'hFFFF, 4'd0, 1'b1, 1'b0, 1'b0);
    // Receive down to empty, then would-block, then a slot never opened.
    send_request(udt_pkg::CMD_RECV,    '0, '0, 4'd1, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_RECV,    '0, '0, 4'd1, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_RECV,    '0, '0, 4'd3, 1'b0, 1'b0, 1'b0);
    // Close, double close, close with a datagram pending, reuse of freed slots.
    send_request(udt_pkg::CMD_CLOSE,   '0, '0, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_CLOSE,   '0, '0, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_CLOSE,   '0, '0, 4'd2, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_OPEN,    32'h1234_5678, 16'h8000, 4'd0, 1'b0, 1'b0, 1'b0);
    send_request(udt_pkg::CMD_OPEN,    32'hC0A8_0001, 16'hFFFF, 4'd0, 1'b0, 1'b0, 1'b0);

    // Open-heavy: table fills up and open starts reporting full.
    wait_idle();
    write_config('0);
    random_phase(300, 5, 1, 3, 2);

    // Balanced mix under a long response hold-off; requests keep coming.
    wait_idle();
    write_config('1);
    hold_off_req = 1'b1;
    random_phase(300, 2, 2, 4, 2);

    // Queue saturation on one socket.
    wait_idle();
    write_config(addr_pool[1]);
    flood_phase(400);

    // Back-to-back stretch with no idling, then a close-heavy mix.
    wait_idle();
    write_config($urandom);
    steady_mode = 1'b1;
    random_phase(200, 3, 2, 4, 2);
    steady_mode = 1'b0;
    random_phase(300, 2, 4, 3, 3);

    wait_idle();
    write_config(addr_pool[2]);
    random_phase(450, 4, 2, 5, 2);

    wait_idle();
    if (mismatch_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
